@@ rtl/ddeo_pkg.sv @@
// ----------------------------------------------------------------------------
// ddeo_pkg
// Shared widths, codes and reset values for the two-wheel encoder odometry.
// ----------------------------------------------------------------------------
package ddeo_pkg;

  // Field widths
  localparam int REQ_W   = 2;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 32;
  localparam int DIST_W  = 48;
  localparam int SPEED_W = 32;

  // Configuration register widths
  localparam int NUM_W    = 40;
  localparam int MMPC_W   = 24;
  localparam int WEIGHT_W = 17;
  localparam int IWB_W    = 16;

  // Configuration channel
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = NUM_W;

  // Serial arithmetic
  localparam int RAW_W     = 31;            // raw speed magnitude
  localparam int DIV_STEPS = NUM_W;         // one quotient bit per cycle
  localparam int MUL_W     = 58;            // accumulator width
  localparam int MUL_STEPS = MMPC_W;        // one multiplier bit per cycle
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h1_0000;
  localparam logic [RAW_W-1:0]    RAW_MAX    = 31'h7FFF_FFFF;
  localparam logic [DIST_W-1:0]   DIST_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic [MUL_W-1:0]    ROUND_HALF = 58'd32768;

  // Reset values of the configuration registers
  localparam logic [NUM_W-1:0]    RST_SPEED_NUM = 40'd65536000000;
  localparam logic [MMPC_W-1:0]   RST_MM_PER_CNT = 24'd65536;
  localparam logic [WEIGHT_W-1:0] RST_WEIGHT    = 17'd9830;
  localparam logic [IWB_W-1:0]    RST_INV_BASE  = 16'd655;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK_A = 2'd0,
    REQ_TICK_B = 2'd1,
    REQ_UPDATE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_NUM  = 8'd0,
    REG_MM_PER_CNT = 8'd1,
    REG_WEIGHT     = 8'd2,
    REG_INV_BASE   = 8'd3
  } cfg_reg_t;

endpackage

@@ rtl/ddeo_if.sv @@
// ----------------------------------------------------------------------------
// ddeo_if
// Channel interfaces: request, result and configuration write.
// ----------------------------------------------------------------------------
interface ddeo_req_if;
  logic                         valid;
  logic                         ready;
  logic [ddeo_pkg::REQ_W-1:0]  req_type;
  logic [ddeo_pkg::TIME_W-1:0] time_stamp;
  logic                         dir_a;
  logic                         dir_b;

  modport source (output valid, req_type, time_stamp, dir_a, dir_b, input ready);
  modport sink   (input valid, req_type, time_stamp, dir_a, dir_b, output ready);
endinterface

interface ddeo_res_if;
  logic                                 valid;
  logic                                 ready;
  logic [ddeo_pkg::COUNT_W-1:0]        count_a;
  logic [ddeo_pkg::COUNT_W-1:0]        count_b;
  logic [ddeo_pkg::DIST_W-1:0]         distance;
  logic signed [ddeo_pkg::SPEED_W-1:0] speed_a;
  logic signed [ddeo_pkg::SPEED_W-1:0] speed_b;
  logic signed [ddeo_pkg::SPEED_W-1:0] angular_rate;

  modport source (output valid, count_a, count_b, distance, speed_a, speed_b,
                  angular_rate, input ready);
  modport sink   (input valid, count_a, count_b, distance, speed_a, speed_b,
                  angular_rate, output ready);
endinterface

interface ddeo_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ddeo_pkg::CFG_IDX_W-1:0]  index;
  logic [ddeo_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/diff_drive_encoder_odometry_top.sv @@
// Sequence: a tick runs the restoring divider; a zero-interval tick and a clear skip it;
//   an update makes six passes of 1 load + 24 steps through one bit-serial multiplier.
// Throughput: one transaction at a time; the next request is taken the cycle after the
//   result moves into the output register, which may still be waiting on the sink.
// Reset: synchronous rst clears counts, timestamps, speeds, rate and distance, and loads the
//   configuration defaults; no clearing pass.
// ----------------------------------------------------------------------------
// diff_drive_encoder_odometry_top
// Two-wheel encoder odometry: period-based wheel speed from a serial divider,
// exponential speed filter, angular rate and distance from a serial multiplier.
// ----------------------------------------------------------------------------
module diff_drive_encoder_odometry_top (
  input  logic        clk,
  input  logic        rst,
  ddeo_cfg_if.sink    cfg,
  ddeo_req_if.sink    req,
  ddeo_res_if.source  res
);

  // Main sequencer
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_MLOAD = 5'b00100,
    S_MUL   = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  // Passes of the shared multiplier during an update
  typedef enum logic [2:0] {
    P_EMA_A_NEW = 3'd0,   // 0.5 + w * signed raw A
    P_EMA_A_OLD = 3'd1,   //   + (1 - w) * filtered A
    P_EMA_B_NEW = 3'd2,
    P_EMA_B_OLD = 3'd3,
    P_TURN      = 3'd4,   // 0.5 + (B - A) * inverse wheel base
    P_DIST      = 3'd5    // (count A + count B) * mm per count
  } phase_t;

  state_t state;
  phase_t phase;

  // Configuration registers
  logic [ddeo_pkg::NUM_W-1:0]    speed_num;
  logic [ddeo_pkg::MMPC_W-1:0]   mm_per_cnt;
  logic [ddeo_pkg::WEIGHT_W-1:0] weight;
  logic [ddeo_pkg::IWB_W-1:0]    inv_base;

  // Odometry state
  logic [ddeo_pkg::COUNT_W-1:0]        ticks_a, ticks_b;
  logic [ddeo_pkg::TIME_W-1:0]         last_a, last_b;
  logic [ddeo_pkg::RAW_W-1:0]          raw_a, raw_b;
  logic signed [ddeo_pkg::SPEED_W-1:0] filt_a, filt_b, turn_rate;
  logic [ddeo_pkg::DIST_W-1:0]         travelled;

  // Latched request attributes
  logic tick_b;
  logic fwd_a, fwd_b;

  // Serial divider: numerator shifts out at the top, quotient shifts in below
  logic [ddeo_pkg::NUM_W-1:0]     div_num;
  logic [ddeo_pkg::TIME_W-1:0]    div_rem;
  logic [ddeo_pkg::TIME_W-1:0]    div_den;
  logic [ddeo_pkg::DIV_CNT_W-1:0] div_cnt;

  // Serial multiplier: LSB-first over the multiplier, shifted multiplicand
  logic [ddeo_pkg::MUL_W-1:0]     mul_acc;
  logic [ddeo_pkg::MUL_W-1:0]     mul_mcand;
  logic [ddeo_pkg::MUL_STEPS-1:0] mul_mplier;
  logic [ddeo_pkg::MUL_CNT_W-1:0] mul_cnt;

  // Output register
  logic                                res_valid;
  logic [ddeo_pkg::COUNT_W-1:0]        out_count_a, out_count_b;
  logic [ddeo_pkg::DIST_W-1:0]         out_distance;
  logic signed [ddeo_pkg::SPEED_W-1:0] out_speed_a, out_speed_b, out_rate;

  logic req_fire, cfg_fire, out_free;

  // Combinational step logic
  logic [ddeo_pkg::TIME_W-1:0]   tick_dt;
  logic [ddeo_pkg::TIME_W:0]     div_shift;
  logic [ddeo_pkg::TIME_W+1:0]   div_diff;
  logic                          div_take;
  logic [ddeo_pkg::NUM_W-1:0]    div_q_next;
  logic [ddeo_pkg::TIME_W-1:0]   div_rem_next;
  logic [ddeo_pkg::RAW_W-1:0]    div_raw;
  logic [ddeo_pkg::MUL_W-1:0]    mul_acc_next;
  logic [ddeo_pkg::WEIGHT_W-1:0] w_sat, w_rest;
  logic [32:0]                   s_a, s_b, filt_diff, tick_sum;
  logic [33:0]                   rate_wide;
  logic signed [ddeo_pkg::SPEED_W-1:0] rate_sat;
  logic [ddeo_pkg::DIST_W-1:0]   dist_sat;

  assign req_fire  = req.valid && req.ready;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign out_free  = !res_valid || res.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign res.valid        = res_valid;
  assign res.count_a      = out_count_a;
  assign res.count_b      = out_count_b;
  assign res.distance     = out_distance;
  assign res.speed_a      = out_speed_a;
  assign res.speed_b      = out_speed_b;
  assign res.angular_rate = out_rate;

  // Interval since this wheel's previous tick, modulo the timer width
  assign tick_dt = req.time_stamp -
                   ((req.req_type == ddeo_pkg::REQ_TICK_B) ? last_b : last_a);

  // Restoring division step
  always_comb begin
    div_shift    = {div_rem, div_num[ddeo_pkg::NUM_W-1]};
    div_diff     = {1'b0, div_shift} - {2'b00, div_den};
    div_take     = !div_diff[ddeo_pkg::TIME_W+1];
    div_q_next   = {div_num[ddeo_pkg::NUM_W-2:0], div_take};
    div_rem_next = div_take ? div_diff[ddeo_pkg::TIME_W-1:0]
                            : div_shift[ddeo_pkg::TIME_W-1:0];
    // saturate quotients that do not fit 31 bits
    div_raw = (|div_q_next[ddeo_pkg::NUM_W-1:ddeo_pkg::RAW_W]) ? ddeo_pkg::RAW_MAX
                                                               : div_q_next[ddeo_pkg::RAW_W-1:0];
  end

  // Multiply step and operand preparation
  always_comb begin
    mul_acc_next = mul_mplier[0] ? (mul_acc + mul_mcand) : mul_acc;
    w_sat  = weight[ddeo_pkg::WEIGHT_W-1] ? ddeo_pkg::WEIGHT_ONE : weight;
    w_rest = ddeo_pkg::WEIGHT_ONE - w_sat;
    s_a = fwd_a ? {2'b00, raw_a} : (33'd0 - {2'b00, raw_a});
    s_b = fwd_b ? {2'b00, raw_b} : (33'd0 - {2'b00, raw_b});
    filt_diff = {filt_b[31], filt_b} - {filt_a[31], filt_a};
    tick_sum  = {1'b0, ticks_a} + {1'b0, ticks_b};
    // floor of the rounded rate, then clamp to 32-bit signed
    rate_wide = mul_acc_next[49:16];
    if (rate_wide[33:31] == 3'b000 || rate_wide[33:31] == 3'b111) begin
      rate_sat = rate_wide[31:0];
    end else if (rate_wide[33]) begin
      rate_sat = 32'sh8000_0000;
    end else begin
      rate_sat = 32'sh7FFF_FFFF;
    end
    // halve the product, clamp to 48 bits
    dist_sat = (|mul_acc_next[56:49]) ? ddeo_pkg::DIST_MAX : mul_acc_next[48:1];
  end

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_num  <= ddeo_pkg::RST_SPEED_NUM;
      mm_per_cnt <= ddeo_pkg::RST_MM_PER_CNT;
      weight     <= ddeo_pkg::RST_WEIGHT;
      inv_base   <= ddeo_pkg::RST_INV_BASE;
    end else if (cfg_fire) begin
      unique case (cfg.index)
        ddeo_pkg::REG_SPEED_NUM:  speed_num  <= cfg.data;
        ddeo_pkg::REG_MM_PER_CNT: mm_per_cnt <= cfg.data[ddeo_pkg::MMPC_W-1:0];
        ddeo_pkg::REG_WEIGHT:     weight     <= cfg.data[ddeo_pkg::WEIGHT_W-1:0];
        ddeo_pkg::REG_INV_BASE:   inv_base   <= cfg.data[ddeo_pkg::IWB_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and odometry state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= P_EMA_A_NEW;
      ticks_a   <= '0;
      ticks_b   <= '0;
      last_a    <= '0;
      last_b    <= '0;
      raw_a     <= '0;
      raw_b     <= '0;
      filt_a    <= '0;
      filt_b    <= '0;
      turn_rate <= '0;
      travelled <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            fwd_a  <= req.dir_a;
            fwd_b  <= req.dir_b;
            tick_b <= (req.req_type == ddeo_pkg::REQ_TICK_B);
            case (req.req_type)
              ddeo_pkg::REQ_TICK_A, ddeo_pkg::REQ_TICK_B: begin
                if (req.req_type == ddeo_pkg::REQ_TICK_B) begin
                  ticks_b <= ticks_b + 1'b1;
                  last_b  <= req.time_stamp;
                end else begin
                  ticks_a <= ticks_a + 1'b1;
                  last_a  <= req.time_stamp;
                end
                if (tick_dt == '0) begin
                  // zero interval: speed saturates
                  if (req.req_type == ddeo_pkg::REQ_TICK_B) begin
                    raw_b <= ddeo_pkg::RAW_MAX;
                  end else begin
                    raw_a <= ddeo_pkg::RAW_MAX;
                  end
                  state <= S_FIN;
                end else begin
                  div_num <= speed_num;
                  div_rem <= '0;
                  div_den <= tick_dt;
                  div_cnt <= '0;
                  state   <= S_DIV;
                end
              end
              ddeo_pkg::REQ_UPDATE: begin
                phase <= P_EMA_A_NEW;
                state <= S_MLOAD;
              end
              default: begin
                // clear counts and distance; speeds are kept
                ticks_a   <= '0;
                ticks_b   <= '0;
                travelled <= '0;
                state     <= S_FIN;
              end
            endcase
          end
        end

        S_DIV: begin
          div_num <= div_q_next;
          div_rem <= div_rem_next;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == ddeo_pkg::DIV_CNT_W'(ddeo_pkg::DIV_STEPS - 1)) begin
            if (tick_b) begin
              raw_b <= div_raw;
            end else begin
              raw_a <= div_raw;
            end
            state <= S_FIN;
          end
        end

        S_MLOAD: begin
          mul_cnt <= '0;
          case (phase)
            P_EMA_A_NEW: begin
              mul_acc    <= ddeo_pkg::ROUND_HALF;
              mul_mcand  <= {{25{s_a[32]}}, s_a};
              mul_mplier <= {7'd0, w_sat};
            end
            P_EMA_A_OLD: begin
              mul_mcand  <= {{26{filt_a[31]}}, filt_a};
              mul_mplier <= {7'd0, w_rest};
            end
            P_EMA_B_NEW: begin
              mul_acc    <= ddeo_pkg::ROUND_HALF;
              mul_mcand  <= {{25{s_b[32]}}, s_b};
              mul_mplier <= {7'd0, w_sat};
            end
            P_EMA_B_OLD: begin
              mul_mcand  <= {{26{filt_b[31]}}, filt_b};
              mul_mplier <= {7'd0, w_rest};
            end
            P_TURN: begin
              mul_acc    <= ddeo_pkg::ROUND_HALF;
              mul_mcand  <= {{25{filt_diff[32]}}, filt_diff};
              mul_mplier <= {8'd0, inv_base};
            end
            default: begin
              mul_acc    <= '0;
              mul_mcand  <= {25'd0, tick_sum};
              mul_mplier <= mm_per_cnt;
            end
          endcase
          state <= S_MUL;
        end

        S_MUL: begin
          mul_acc    <= mul_acc_next;
          mul_mcand  <= {mul_mcand[ddeo_pkg::MUL_W-2:0], 1'b0};
          mul_mplier <= {1'b0, mul_mplier[ddeo_pkg::MUL_STEPS-1:1]};
          mul_cnt    <= mul_cnt + 1'b1;
          if (mul_cnt == ddeo_pkg::MUL_CNT_W'(ddeo_pkg::MUL_STEPS - 1)) begin
            // distance is the last pass
            state <= (phase == P_DIST) ? S_FIN : S_MLOAD;
            case (phase)
              P_EMA_A_NEW: phase <= P_EMA_A_OLD;
              P_EMA_A_OLD: begin
                filt_a <= mul_acc_next[47:16];
                phase  <= P_EMA_B_NEW;
              end
              P_EMA_B_NEW: phase <= P_EMA_B_OLD;
              P_EMA_B_OLD: begin
                filt_b <= mul_acc_next[47:16];
                phase  <= P_TURN;
              end
              P_TURN: begin
                turn_rate <= rate_sat;
                phase     <= P_DIST;
              end
              default: begin
                travelled <= dist_sat;
              end
            endcase
          end
        end

        S_FIN: begin
          // hand the post-request state to the output register
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Output valid: set as a finished transaction loads, cleared when the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      out_count_a  <= ticks_a;
      out_count_b  <= ticks_b;
      out_distance <= travelled;
      out_speed_a  <= filt_a;
      out_speed_b  <= filt_b;
      out_rate     <= turn_rate;
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the two-wheel encoder odometry block
// Drives tick, update and clear requests through the request channel and
// predicts every result: counts, filtered speeds, turn rate and distance.
// The run opens with a directed sequence of corner cases. Random phases
// follow, and each phase starts from its own register setting. Both
// channels idle at random, and one long sink stall backs up the block.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ddeo_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 141;
  localparam int TAIL_CYCLES = 200;   // comfortably past an update
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hFF;
  localparam longint RATE_HI = 64'sd2147483647;
  localparam longint RATE_LO = -64'sd2147483648;

  // One result transaction, in port order
  typedef struct packed {
    logic [COUNT_W-1:0]        count_a;
    logic [COUNT_W-1:0]        count_b;
    logic [DIST_W-1:0]         distance;
    logic signed [SPEED_W-1:0] speed_a;
    logic signed [SPEED_W-1:0] speed_b;
    logic signed [SPEED_W-1:0] angular_rate;
  } odo_res_t;

  // Directed rows: a request checked by prediction, a request with its result
  // written out, or a register write
  typedef enum logic [1:0] {ROW_STEP, ROW_KNOWN, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    req_t                  op;
    logic [CFG_DATA_W-1:0] val;    // time stamp, or register data
    logic [CFG_IDX_W-1:0]  idx;
    logic                  da;
    logic                  db;
    odo_res_t              want;
  } stim_row_t;

  logic clk;
  logic rst;

  ddeo_cfg_if cfg_bus ();
  ddeo_req_if req_bus ();
  ddeo_res_if res_bus ();

  diff_drive_encoder_odometry_top uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_bus),
    .req (req_bus),
    .res (res_bus)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Odometry predictor: register copy and state, starting from reset values
  // --------------------------------------------------------------------------
  logic [NUM_W-1:0]    speed_num = RST_SPEED_NUM;
  logic [MMPC_W-1:0]   mm_pc     = RST_MM_PER_CNT;
  logic [WEIGHT_W-1:0] alpha     = RST_WEIGHT;
  logic [IWB_W-1:0]    inv_base  = RST_INV_BASE;

  logic [COUNT_W-1:0]        cnt_a   = '0;
  logic [COUNT_W-1:0]        cnt_b   = '0;
  logic [TIME_W-1:0]         stamp_a = '0;
  logic [TIME_W-1:0]         stamp_b = '0;
  logic [RAW_W-1:0]          raw_a   = '0;
  logic [RAW_W-1:0]          raw_b   = '0;
  logic signed [SPEED_W-1:0] spd_a   = '0;
  logic signed [SPEED_W-1:0] spd_b   = '0;
  logic signed [SPEED_W-1:0] turn    = '0;
  logic [DIST_W-1:0]         dist_mm = '0;

  odo_res_t expected_odo[$];   // predicted results, oldest first

  int mismatches   = 0;
  int results_seen = 0;
  int n_tick       = 0;
  int n_update     = 0;
  int n_clear      = 0;
  int n_settings   = 0;

  // Register write as the block sees it: bits above the width drop,
  // unmapped indexes do nothing
  function automatic void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_SPEED_NUM:  speed_num = v[NUM_W-1:0];
      REG_MM_PER_CNT: mm_pc     = v[MMPC_W-1:0];
      REG_WEIGHT:     alpha     = v[WEIGHT_W-1:0];
      REG_INV_BASE:   inv_base  = v[IWB_W-1:0];
      default: ;
    endcase
  endfunction

  // Speed magnitude from a tick interval; zero interval or overflow pins it
  function automatic logic [RAW_W-1:0] period_rate(logic [TIME_W-1:0] dt);
    logic [NUM_W-1:0] q;
    if (dt == '0) return RAW_MAX;
    q = speed_num / NUM_W'(dt);
    return (q > NUM_W'(RAW_MAX)) ? RAW_MAX : q[RAW_W-1:0];
  endfunction

  // One exponential filter step, rounded half up, floor on negatives
  function automatic logic signed [SPEED_W-1:0] ema_step(logic [RAW_W-1:0] raw, logic fwd,
                                                         logic signed [SPEED_W-1:0] prev);
    longint w, s, acc;
    // weights above one behave as one
    w   = (alpha > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(alpha);
    s   = fwd ? longint'(raw) : -longint'(raw);
    acc = w * s + (64'sd65536 - w) * longint'(prev) + 64'sd32768;
    return SPEED_W'(acc >>> 16);
  endfunction

  function automatic odo_res_t odometry_predict(req_t op, logic [TIME_W-1:0] ts,
                                                logic fwd_a, logic fwd_b);
    longint      diff, rate;
    logic [63:0] span;
    case (op)
      REQ_TICK_A: begin
        cnt_a   = cnt_a + 1'b1;
        raw_a   = period_rate(ts - stamp_a);
        stamp_a = ts;
      end
      REQ_TICK_B: begin
        cnt_b   = cnt_b + 1'b1;
        raw_b   = period_rate(ts - stamp_b);
        stamp_b = ts;
      end
      REQ_UPDATE: begin
        spd_a = ema_step(raw_a, fwd_a, spd_a);
        spd_b = ema_step(raw_b, fwd_b, spd_b);
        diff  = longint'(spd_b) - longint'(spd_a);
        rate  = (diff * longint'(inv_base) + 64'sd32768) >>> 16;
        if (rate > RATE_HI) rate = RATE_HI;
        if (rate < RATE_LO) rate = RATE_LO;
        turn  = SPEED_W'(rate);
        // 33-bit count sum, halved after the scale
        span    = ((64'(cnt_a) + 64'(cnt_b)) * 64'(mm_pc)) >> 1;
        dist_mm = (span > 64'(DIST_MAX)) ? DIST_MAX : span[DIST_W-1:0];
      end
      default: begin
        // clear keeps speeds, rate and tick stamps
        cnt_a   = '0;
        cnt_b   = '0;
        dist_mm = '0;
      end
    endcase
    return odo_res_t'{cnt_a, cnt_b, dist_mm, spd_a, spd_b, turn};
  endfunction

  // --------------------------------------------------------------------------
  // Directed row builders
  // --------------------------------------------------------------------------
  function automatic stim_row_t step_row(req_t op, logic [TIME_W-1:0] ts, logic da, logic db);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_STEP;
    row.op   = op;
    row.val  = CFG_DATA_W'(ts);
    row.da   = da;
    row.db   = db;
    return row;
  endfunction

  function automatic stim_row_t known_row(req_t op, logic [TIME_W-1:0] ts, logic da, logic db,
                                          odo_res_t want);
    stim_row_t row;
    row      = step_row(op, ts, da, db);
    row.kind = ROW_KNOWN;
    row.want = want;
    return row;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_REG;
    row.idx  = idx;
    row.val  = v;
    return row;
  endfunction

  // Register value for a random phase: zero, all ones, junk in the upper
  // bits, or something in a useful range. First phase restores the reset
  // values, last phase pins every register at its top.
  function automatic logic [CFG_DATA_W-1:0] reg_choice(cfg_reg_t r, int ph);
    logic [CFG_DATA_W-1:0] pick;
    case ($urandom_range(0, 4))
      0: pick = '0;
      1: pick = '1;
      2: pick = {8'($urandom), $urandom};
      default: begin
        case (r)
          REG_SPEED_NUM:  pick = CFG_DATA_W'($urandom_range(1, 200000)) << 16;
          REG_MM_PER_CNT: pick = CFG_DATA_W'($urandom_range(0, 32'hFF_FFFF));
          REG_WEIGHT:     pick = CFG_DATA_W'($urandom_range(0, 32'(WEIGHT_ONE)));
          default:        pick = CFG_DATA_W'($urandom_range(0, 32'hFFFF));
        endcase
      end
    endcase
    if (ph == 0) begin
      case (r)
        REG_SPEED_NUM:  pick = CFG_DATA_W'(RST_SPEED_NUM);
        REG_MM_PER_CNT: pick = CFG_DATA_W'(RST_MM_PER_CNT);
        REG_WEIGHT:     pick = CFG_DATA_W'(RST_WEIGHT);
        default:        pick = CFG_DATA_W'(RST_INV_BASE);
      endcase
    end
    if (ph == PHASES - 1) pick = '1;
    return pick;
  endfunction

  // --------------------------------------------------------------------------
  // Channel tasks. All are entered at a rising edge and return at one.
  // --------------------------------------------------------------------------

  // Offer one request and hold it until the block accepts it; the result
  // is predicted at acceptance. A written-out result replaces the prediction
  // in the queue, the predictor still advances.
  task automatic offer(req_t op, logic [TIME_W-1:0] ts, logic da, logic db,
                       bit fixed, odo_res_t fixed_res);
    odo_res_t pred;
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= op;
    req_bus.time_stamp <= ts;
    req_bus.dir_a      <= da;
    req_bus.dir_b      <= db;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    pred = odometry_predict(op, ts, da, db);
    expected_odo.push_back(fixed ? fixed_res : pred);
    case (op)
      REQ_UPDATE: n_update++;
      REQ_CLEAR:  n_clear++;
      default:    n_tick++;
    endcase
  endtask

  // Sender gap with valid dropped, n >= 1
  task automatic idle_req(int n);
    req_bus.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic settle();
    if (req_bus.valid) req_bus.valid <= 1'b0;
    while (expected_odo.size() != 0) @(posedge clk);
  endtask

  // One register write; valid stays up so writes can go back to back,
  // the caller drops it after the last one
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    set_reg(idx, v);
  endtask

  // --------------------------------------------------------------------------
  // Result sink: compare every transaction, stall on a changing pattern
  // --------------------------------------------------------------------------
  bit [31:0] cyc       = '0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;

  task automatic check_field(string name, logic [DIST_W-1:0] want, logic [DIST_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %h got %h", $time, name, want, got);
    end
  endtask

  // Long hold-off, counted here: once 400 results are in, the sink refuses
  // while hold_left counts down and the source keeps offering, so the block backs up
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen == 400) begin
      hold_left <= 600;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    odo_res_t want_res;
    logic     rdy;
    cyc <= cyc + 1;
    if (!rst && res_bus.valid && res_bus.ready) begin
      results_seen <= results_seen + 1;
      if (expected_odo.size() == 0) begin
        mismatches++;
        $display("%0t ns: result transaction with nothing expected", $time);
      end else begin
        want_res = expected_odo.pop_front();
        check_field("count_a", DIST_W'(want_res.count_a), DIST_W'(res_bus.count_a));
        check_field("count_b", DIST_W'(want_res.count_b), DIST_W'(res_bus.count_b));
        check_field("distance", want_res.distance, res_bus.distance);
        check_field("speed_a", DIST_W'(want_res.speed_a), DIST_W'(res_bus.speed_a));
        check_field("speed_b", DIST_W'(want_res.speed_b), DIST_W'(res_bus.speed_b));
        check_field("angular_rate", DIST_W'(want_res.angular_rate),
                    DIST_W'(res_bus.angular_rate));
      end
    end
    // stall pattern rotates with cyc[9:8]; one slot never stalls
    case (cyc[9:8])
      2'd0:    rdy = 1'b1;
      2'd1:    rdy = 1'($urandom_range(0, 1));
      2'd2:    rdy = (cyc % 5) != 0;
      default: rdy = $urandom_range(0, 7) != 0;
    endcase
    res_bus.ready <= rdy && (hold_left == 0);
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t         plan[$];
    int                burst_left, roll;
    logic [TIME_W-1:0] now_ts;
    logic [TIME_W-1:0] ts;
    req_t              op;
    logic              da, db;

    clk                = 1'b0;
    rst                = 1'b1;
    req_bus.valid      = 1'b0;
    req_bus.req_type   = REQ_TICK_A;
    req_bus.time_stamp = '0;
    req_bus.dir_a      = 1'b0;
    req_bus.dir_b      = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = REG_SPEED_NUM;
    cfg_bus.data       = '0;
    res_bus.ready      = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed corner cases. Results are written out where they follow
    // directly from reset state or from saturation.
    plan = '{
      // update straight out of reset: everything zero
      known_row(REQ_UPDATE, 32'd0, 1'b1, 1'b1,
                odo_res_t'{32'd0, 32'd0, 48'd0, 32'sd0, 32'sd0, 32'sd0}),
      // first tick measures from stamp zero, here a zero interval
      known_row(REQ_TICK_A, 32'd0, 1'b1, 1'b1,
                odo_res_t'{32'd1, 32'd0, 48'd0, 32'sd0, 32'sd0, 32'sd0}),
      known_row(REQ_TICK_A, 32'd0, 1'b0, 1'b0,
                odo_res_t'{32'd2, 32'd0, 48'd0, 32'sd0, 32'sd0, 32'sd0}),
      known_row(REQ_TICK_B, 32'd1000, 1'b1, 1'b1,
                odo_res_t'{32'd2, 32'd1, 48'd0, 32'sd0, 32'sd0, 32'sd0}),
      step_row(REQ_UPDATE, 32'd0, 1'b1, 1'b1),
      step_row(REQ_TICK_A, 32'hFFFF_FFFF, 1'b0, 1'b0),   // longest interval
      step_row(REQ_TICK_A, 32'd5, 1'b1, 1'b0),           // timer wraps
      step_row(REQ_UPDATE, 32'h5555_AAAA, 1'b0, 1'b0),
      step_row(REQ_UPDATE, 32'hAAAA_5555, 1'b0, 1'b1),
      step_row(REQ_UPDATE, 32'hFFFF_FFFF, 1'b1, 1'b0),
      step_row(REQ_CLEAR, 32'hFFFF_FFFF, 1'b1, 1'b1),
      // full weight passes raw speeds straight through; widest base factor
      reg_row(REG_WEIGHT, CFG_DATA_W'(WEIGHT_ONE)),
      reg_row(REG_INV_BASE, 40'h00_0000_FFFF),
      reg_row(REG_SPEED_NUM, 40'hFF_FFFF_FFFF),
      step_row(REQ_TICK_A, 32'd7, 1'b0, 1'b1),
      step_row(REQ_TICK_B, 32'd1000, 1'b1, 1'b0),        // zero interval again
      // opposite full speeds: turn rate pinned at both ends
      known_row(REQ_UPDATE, 32'd0, 1'b0, 1'b1,
                odo_res_t'{32'd1, 32'd1, 48'd65536, -32'sd2147483647,
                           32'sd2147483647, 32'sh7FFF_FFFF}),
      known_row(REQ_UPDATE, 32'd0, 1'b1, 1'b0,
                odo_res_t'{32'd1, 32'd1, 48'd65536, 32'sd2147483647,
                           -32'sd2147483647, 32'sh8000_0000}),
      // weight above one, numerator zero, upper data bits, unmapped index
      reg_row(REG_WEIGHT, 40'hFF_FFFF_FFFF),
      reg_row(REG_SPEED_NUM, 40'h00_0000_0000),
      reg_row(REG_MM_PER_CNT, 40'hFF_FFFF_FFFF),
      reg_row(REG_UNMAPPED, 40'hFF_FFFF_FFFF),
      step_row(REQ_TICK_A, 32'd8, 1'b1, 1'b1),
      step_row(REQ_UPDATE, 32'd0, 1'b1, 1'b1),
      // zero weight holds the filter, zero base and scale
      reg_row(REG_WEIGHT, 40'h00_0000_0000),
      reg_row(REG_INV_BASE, 40'h00_0000_0000),
      reg_row(REG_MM_PER_CNT, 40'h00_0000_0000),
      step_row(REQ_UPDATE, 32'd0, 1'b0, 1'b0),
      step_row(REQ_TICK_B, 32'd0, 1'b1, 1'b1),
      step_row(REQ_UPDATE, 32'd0, 1'b1, 1'b1),
      step_row(REQ_CLEAR, 32'd0, 1'b0, 1'b0),
      step_row(REQ_UPDATE, 32'd0, 1'b0, 1'b1)
    };

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        // registers only change with nothing in flight
        settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        if (cfg_bus.valid) cfg_bus.valid <= 1'b0;
        offer(plan[i].op, plan[i].val[TIME_W-1:0], plan[i].da, plan[i].db,
              plan[i].kind == ROW_KNOWN, plan[i].want);
      end
    end
    n_settings = 4;

    // Random phases. Most traffic is a plausible encoder stream: a timer
    // that moves forward by up to 4000 at a time, ticks on both wheels, periodic
    // updates, the odd clear. A few percent is pure noise.
    now_ts     = $urandom;
    burst_left = $urandom_range(1, 40);
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_reg(REG_SPEED_NUM, reg_choice(REG_SPEED_NUM, ph));
      write_reg(REG_MM_PER_CNT, reg_choice(REG_MM_PER_CNT, ph));
      write_reg(REG_WEIGHT, reg_choice(REG_WEIGHT, ph));
      write_reg(REG_INV_BASE, reg_choice(REG_INV_BASE, ph));
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_IDX_W'($urandom_range(32'(REG_INV_BASE) + 1, 255)),
                  {8'($urandom), $urandom});
      cfg_bus.valid <= 1'b0;
      n_settings++;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          op = req_t'($urandom_range(32'(REQ_TICK_A), 32'(REQ_CLEAR)));
          ts = $urandom;
          da = 1'($urandom_range(0, 1));
          db = 1'($urandom_range(0, 1));
        end else begin
          if (roll < 8)
            now_ts = now_ts + $urandom;                   // large jump
          else if ($urandom_range(0, 9) != 0)
            now_ts = now_ts + $urandom_range(1, 4000);    // zero step otherwise
          if (roll < 40)
            op = REQ_TICK_A;
          else if (roll < 75)
            op = REQ_TICK_B;
          else if (roll < 97)
            op = REQ_UPDATE;
          else
            op = REQ_CLEAR;
          ts = now_ts;
          da = $urandom_range(0, 4) != 0;
          db = $urandom_range(0, 4) != 0;
        end
        offer(op, ts, da, db, 1'b0, odo_res_t'('0));

        // phase 2 streams with no sender gaps
        if (ph != 2) begin
          burst_left--;
          if (burst_left == 0) begin
            idle_req($urandom_range(1, 16));
            burst_left = $urandom_range(1, 40);
          end
        end
        // mid-phase pause until the block has drained
        if (ph == 3 && k == PHASE_ITEMS / 2) settle();
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d ticks, %0d updates, %0d clears across %0d register settings",
             n_tick, n_update, n_clear, n_settings);
    $display("Checked %0d result transactions field by field, %0d mismatches",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #4ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
